/* rtl/pbrd_pkg.sv */
// Shared constants, types and codes for the PackBits row decoder.
`default_nettype none

package pbrd_pkg;

    localparam int MAX_ROW_BYTES = 16384;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 15;
    localparam int UNITS_W = 8;
    localparam int RUN_W   = 9;

    // Configuration register indexes and address width.
    localparam int REG_EXPECTED = 0;
    localparam int REG_PAIR     = 1;
    localparam int ADDR_W       = 3;

    // Decoder phases.
    localparam logic [1:0] PH_CONTROL  = 2'd0;
    localparam logic [1:0] PH_REPEAT_A = 2'd1;
    localparam logic [1:0] PH_REPEAT_B = 2'd2;
    localparam logic [1:0] PH_LITERAL  = 2'd3;

    localparam logic [BYTE_W-1:0] CTRL_REPEAT_BIT = 8'h80;
    localparam logic [RUN_W-1:0]  REPEAT_BASE     = 9'd257;

    // Output queue depth and its count width.
    localparam int QDEPTH = 3;
    localparam int QCNT_W = 2;

    typedef struct packed {
        logic [LEN_W-1:0] expected_bytes;
        logic             pair_mode;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] first_value;
        logic [BYTE_W-1:0] second_value;
        logic [LEN_W-1:0]  run_bytes;
        logic              row_done;
    } t_result;

endpackage

`default_nettype wire

/* rtl/pbrd_cfg.sv */
// Configuration register bank with its APB-style access port.
`default_nettype none

module pbrd_cfg (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [pbrd_pkg::ADDR_W-1:0]   paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output pbrd_pkg::t_cfg               o_cfg
);

    logic [pbrd_pkg::LEN_W-1:0] r_expected;
    logic                       r_pair;
    logic                       wr_en;
    logic                       sel_pair;

    // Registers sit on 4-byte boundaries; bit 2 picks the register.
    assign sel_pair = (paddr[2] == 1'(pbrd_pkg::REG_PAIR));
    assign wr_en    = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= '0;
            r_pair     <= 1'b0;
        end else if (wr_en) begin
            if (sel_pair) begin
                r_pair <= pwdata[0];
            end else begin
                r_expected <= pwdata[pbrd_pkg::LEN_W-1:0];
            end
        end
    end

    always_comb begin
        if (sel_pair) begin
            prdata = {31'd0, r_pair};
        end else begin
            prdata = {{(32 - pbrd_pkg::LEN_W){1'b0}}, r_expected};
        end
    end

    assign o_cfg.expected_bytes = r_expected;
    assign o_cfg.pair_mode      = r_pair;

endmodule

`default_nettype wire

/* rtl/pbrd_core.sv */
// PackBits phase tracking, run clipping and row-end fill computation.
`default_nettype none

module pbrd_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  pbrd_pkg::t_cfg                   i_cfg,
    input  wire                              i_accept,
    input  wire [pbrd_pkg::BYTE_W-1:0]       i_byte,
    input  wire                              i_last,
    output logic [1:0]                       o_push,
    output pbrd_pkg::t_result                o_res0,
    output pbrd_pkg::t_result                o_res1
);

    logic [1:0]                    r_phase, n_phase;
    logic [pbrd_pkg::UNITS_W-1:0]  r_units, n_units;
    logic [pbrd_pkg::BYTE_W-1:0]   r_held, n_held;
    logic [pbrd_pkg::LEN_W-1:0]    r_produced, n_produced;
    logic                          r_odd, n_odd;

    logic [pbrd_pkg::LEN_W-1:0]    lim;
    logic [pbrd_pkg::LEN_W-1:0]    avail;
    logic                          row_full;
    logic [pbrd_pkg::RUN_W-1:0]    run_n;
    logic [pbrd_pkg::BYTE_W-1:0]   run_a, run_b;
    logic [pbrd_pkg::LEN_W-1:0]    run_n_ext;
    logic [pbrd_pkg::LEN_W-1:0]    take;
    logic [pbrd_pkg::LEN_W-1:0]    fill;
    logic                          emit;
    logic                          flush;
    pbrd_pkg::t_result             run_res, fill_res;

    always_comb begin
        if (i_cfg.expected_bytes > pbrd_pkg::LEN_W'(pbrd_pkg::MAX_ROW_BYTES)) begin
            lim = pbrd_pkg::LEN_W'(pbrd_pkg::MAX_ROW_BYTES);
        end else begin
            lim = i_cfg.expected_bytes;
        end
    end

    assign row_full = (r_produced >= lim);
    assign avail    = row_full ? '0 : (lim - r_produced);

    always_comb begin
        n_phase = r_phase;
        n_units = r_units;
        n_held  = r_held;
        n_odd   = r_odd;
        run_n   = '0;
        run_a   = i_byte;
        run_b   = i_byte;
        flush   = 1'b0;

        if (!row_full) begin
            unique case (r_phase)
                pbrd_pkg::PH_CONTROL: begin
                    if ((i_byte & pbrd_pkg::CTRL_REPEAT_BIT) != '0) begin
                        n_units = pbrd_pkg::UNITS_W'(pbrd_pkg::REPEAT_BASE
                                                     - {1'b0, i_byte});
                        n_phase = pbrd_pkg::PH_REPEAT_A;
                    end else begin
                        n_units = i_byte + 8'd1;
                        n_odd   = 1'b0;
                        n_phase = pbrd_pkg::PH_LITERAL;
                    end
                end
                pbrd_pkg::PH_REPEAT_A: begin
                    if (i_cfg.pair_mode) begin
                        n_held  = i_byte;
                        n_phase = pbrd_pkg::PH_REPEAT_B;
                    end else begin
                        run_n   = {1'b0, r_units};
                        n_units = '0;
                        n_phase = pbrd_pkg::PH_CONTROL;
                    end
                end
                pbrd_pkg::PH_REPEAT_B: begin
                    run_a   = r_held;
                    run_n   = {r_units, 1'b0};
                    n_units = '0;
                    n_phase = pbrd_pkg::PH_CONTROL;
                end
                pbrd_pkg::PH_LITERAL: begin
                    if (r_odd) begin
                        // Second byte of a literal pair completes the pair.
                        run_a   = r_held;
                        run_n   = 9'd2;
                        n_odd   = 1'b0;
                        n_units = r_units - 8'd1;
                    end else if (i_cfg.pair_mode) begin
                        n_held = i_byte;
                        n_odd  = 1'b1;
                    end else begin
                        run_n   = 9'd1;
                        n_units = r_units - 8'd1;
                    end
                    if (n_units == '0 && !n_odd) begin
                        n_phase = pbrd_pkg::PH_CONTROL;
                    end
                end
                default: begin
                    n_phase = pbrd_pkg::PH_CONTROL;
                end
            endcase
        end

        // A half pair held when the row ends goes out as a one-byte run.
        // It can only be the byte just taken, so no other run is pending.
        if (i_last && !row_full && n_phase == pbrd_pkg::PH_LITERAL && n_odd) begin
            flush = 1'b1;
            run_a = n_held;
            run_b = n_held;
            run_n = 9'd1;
        end
    end

    assign run_n_ext = {{(pbrd_pkg::LEN_W - pbrd_pkg::RUN_W){1'b0}}, run_n};
    assign take      = (run_n_ext > avail) ? avail : run_n_ext;
    assign emit      = (take != '0);
    assign fill      = avail - take;

    always_comb begin
        if (i_last) begin
            n_produced = '0;
        end else begin
            n_produced = r_produced + take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= pbrd_pkg::PH_CONTROL;
            r_units    <= '0;
            r_held     <= '0;
            r_produced <= '0;
            r_odd      <= 1'b0;
        end else if (i_accept) begin
            r_produced <= n_produced;
            if (i_last) begin
                r_phase <= pbrd_pkg::PH_CONTROL;
                r_units <= '0;
                r_held  <= '0;
                r_odd   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_units <= n_units;
                r_held  <= n_held;
                r_odd   <= n_odd;
            end
        end
    end

    assign run_res.first_value  = run_a;
    assign run_res.second_value = run_b;
    assign run_res.run_bytes    = take;
    assign run_res.row_done     = 1'b0;

    assign fill_res.first_value  = '0;
    assign fill_res.second_value = '0;
    assign fill_res.run_bytes    = fill;
    assign fill_res.row_done     = 1'b1;

    assign o_res0    = emit ? run_res : fill_res;
    assign o_res1    = fill_res;
    assign o_push[0] = i_accept && (emit || i_last);
    assign o_push[1] = i_accept && emit && i_last;

endmodule

`default_nettype wire

/* rtl/pbrd_outq.sv */
// Three-entry shifting result queue that takes up to two words per cycle.
`default_nettype none

module pbrd_outq (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire  [1:0]           i_push,
    input  pbrd_pkg::t_result    i_res0,
    input  pbrd_pkg::t_result    i_res1,
    input  wire                  i_ready,
    output logic                 o_valid,
    output pbrd_pkg::t_result    o_head,
    output logic                 o_space
);

    pbrd_pkg::t_result             r_q [pbrd_pkg::QDEPTH];
    pbrd_pkg::t_result             n_q [pbrd_pkg::QDEPTH];
    logic [pbrd_pkg::QCNT_W-1:0]   r_cnt, n_cnt;
    logic                          pop;
    logic [pbrd_pkg::QCNT_W-1:0]   base;
    logic [pbrd_pkg::QCNT_W-1:0]   pos1;

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_q[0];
    assign pop     = o_valid && i_ready;
    // Room for the two words a single byte can produce.
    assign o_space = (r_cnt <= 2'd1);

    assign base  = r_cnt - {1'b0, pop};
    assign pos1  = base + {1'b0, i_push[0]};
    assign n_cnt = base + {1'b0, i_push[0]} + {1'b0, i_push[1]};

    always_comb begin
        for (int j = 0; j < pbrd_pkg::QDEPTH; j++) begin
            if (pop && j < pbrd_pkg::QDEPTH - 1) begin
                n_q[j] = r_q[j + 1];
            end else begin
                n_q[j] = r_q[j];
            end
            if (i_push[0] && base == pbrd_pkg::QCNT_W'(j)) begin
                n_q[j] = i_res0;
            end
            if (i_push[1] && pos1 == pbrd_pkg::QCNT_W'(j)) begin
                n_q[j] = i_res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < pbrd_pkg::QDEPTH; j++) begin
            r_q[j] <= n_q[j];
        end
    end

endmodule

`default_nettype wire

/* rtl/packbits_row_decoder.sv */
// Top level of the PackBits row decoder: register bank, decoder and result queue.
//
// Usage: compressed bytes of one row enter on the s_axis channel, one byte per
// word, with s_axis_tlast on the final byte of the row. Decoded output leaves on
// the m_axis channel as runs: each word names one or two byte values and a run
// length in bytes, and the final word of each row (m_axis_tlast high) carries
// the zero fill that brings the row to the configured length.
// The row length (expected_bytes, address 0) and unit size (pair_mode,
// address 4) are set over the APB port; the user must set them only while no row
// is in progress, as the block itself does not enforce it. Result words are
// registered in the output queue as their bytes are taken. Throughput: one byte
// per cycle while the queue has room. The decoder state update is a single pass
// through the phase logic and a run clip, so only the output queue limits rate:
// a final byte that also closes a run yields two words, and input ready drops while one drains.
// Stall: the three-word result queue keeps taking bytes while a word waits;
// s_axis_tready falls once two or more words are queued.
// Reset: the decoder returns to waiting for a control byte, the configuration
// registers clear to zero and the queue empties.
`default_nettype none

module packbits_row_decoder (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // Compressed input.
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [7:0]                   s_axis_tdata,  // [7:0] packed_byte
    input  wire                          s_axis_tlast,  // last_packed
    // Decoded runs.
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    // [7:0] first_value, [15:8] second_value, [30:16] run_bytes, [31] zero
    output logic [31:0]                  m_axis_tdata,
    output logic                         m_axis_tlast,  // row_done
    // Configuration.
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [pbrd_pkg::ADDR_W-1:0]  paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    pbrd_pkg::t_cfg     cfg;
    pbrd_pkg::t_result  res0, res1, head;
    logic [1:0]         push;
    logic               in_accept;
    logic               space;

    pbrd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign s_axis_tready = space;
    assign in_accept     = s_axis_tvalid && space;

    // The decoder works straight off the accepted byte; its results are
    // registered in the queue in the same cycle.
    pbrd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (in_accept),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_push   (push),
        .o_res0   (res0),
        .o_res1   (res1)
    );

    pbrd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res0  (res0),
        .i_res1  (res1),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_head  (head),
        .o_space (space)
    );

    assign m_axis_tdata = {1'b0, head.run_bytes, head.second_value, head.first_value};
    assign m_axis_tlast = head.row_done;

    // Fill words never carry a byte value.
    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[15:0] == 16'd0))
        else $error("row fill word carries nonzero values");

    // A clipped run of zero bytes is never reported.
    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[30:16] != 15'd0))
        else $error("empty run word emitted");

    // The end of a row always leaves at least its fill word queued.
    a_row_end_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> m_axis_tvalid)
        else $error("row end produced no output word");

endmodule

`default_nettype wire

/* test/tb_packbits_row_decoder.sv */
// Testbench for the PackBits row decoder: a directed table, then random rows checked by a predictor.
`timescale 1ns / 1ps

module tb_packbits_row_decoder;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_WORDS  = 1550;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int IDLE_PCT      = 7;
    // The receiver stops once for a long stretch when this many words have gone in.
    localparam int HOLD_AT       = 700;
    localparam int HOLD_CYCLES   = 400;
    // Neither side idles while the word count lies in this window.
    localparam int QUIET_FROM    = 1000;
    localparam int QUIET_TO      = 1250;
    // Settle time that covers a result leaving the queue and a second word behind it.
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 12;

    typedef enum logic {STEP_WORD, STEP_CFG} t_step_kind;

    // One row of the directed table: either an input word or a register write.
    // A typed row carries its single result as written; other rows use the predictor.
    typedef struct {
        t_step_kind          kind;
        int                  idx;
        logic [31:0]         value;
        logic                last;
        logic                typed;
        pbrd_pkg::t_result   want;
    } t_step;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    wire                           s_axis_tready;
    logic [7:0]                    s_axis_tdata  = 8'h00;
    logic                          s_axis_tlast  = 1'b0;
    wire                           m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    wire  [31:0]                   m_axis_tdata;
    wire                           m_axis_tlast;
    logic                          psel          = 1'b0;
    logic                          penable       = 1'b0;
    logic                          pwrite        = 1'b0;
    logic [pbrd_pkg::ADDR_W-1:0]   paddr         = '0;
    logic [31:0]                   pwdata        = '0;
    wire  [31:0]                   prdata;
    wire                           pready;

    packbits_row_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Testbench copy of the configuration and of the decoder state.
    logic [pbrd_pkg::LEN_W-1:0]   cfg_expected = '0;
    logic                         cfg_pair     = 1'b0;
    logic [1:0]                   dec_phase    = pbrd_pkg::PH_CONTROL;
    logic [pbrd_pkg::UNITS_W-1:0] units_left   = '0;
    logic [pbrd_pkg::BYTE_W-1:0]  held_byte    = '0;
    int                           produced     = 0;
    logic                         literal_odd  = 1'b0;
    logic                         row_full     = 1'b0;

    pbrd_pkg::t_result pending_runs[$];   // runs still owed by the decoder, oldest first
    pbrd_pkg::t_result step_runs[$];      // runs caused by the byte just decoded
    t_step             dir_steps[$];

    int words_in     = 0;
    int runs_checked = 0;
    int err_cnt      = 0;
    int cycle_cnt    = 0;
    int hold_left    = 0;
    logic hold_done  = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on run %0d, %s: got %0d, expected %0d",
                 $time, runs_checked, what, got, want);
        err_cnt++;
    endtask

    function automatic logic quiet_window();
        return words_in >= QUIET_FROM && words_in < QUIET_TO;
    endfunction

    // Lengths above the largest row are treated as the largest row.
    function automatic int row_limit();
        return (int'(cfg_expected) > pbrd_pkg::MAX_ROW_BYTES) ? pbrd_pkg::MAX_ROW_BYTES
                                                              : int'(cfg_expected);
    endfunction

    task automatic clear_row();
        dec_phase   = pbrd_pkg::PH_CONTROL;
        units_left  = '0;
        held_byte   = '0;
        produced    = 0;
        literal_odd = 1'b0;
        row_full    = 1'b0;
    endtask

    // Clip a run to the room left in the row; a run clipped to nothing is dropped.
    task automatic emit_run(input logic [7:0] a, input logic [7:0] b, input int n);
        int                lim;
        int                avail;
        int                take;
        pbrd_pkg::t_result r;
        lim   = row_limit();
        avail = (produced < lim) ? lim - produced : 0;
        take  = (n < avail) ? n : avail;
        if (take == 0) begin
            return;
        end
        produced += take;
        row_full = (produced >= lim);
        r.first_value  = a;
        r.second_value = b;
        r.run_bytes    = pbrd_pkg::LEN_W'(take);
        r.row_done     = 1'b0;
        step_runs.insert(step_runs.size(), r);
    endtask

    // Advance the decoder copy by one packed byte and collect the runs it causes.
    task automatic decode_byte(input logic [7:0] b, input logic last);
        int                lim;
        pbrd_pkg::t_result r;
        step_runs.delete();
        lim      = row_limit();
        row_full = (produced >= lim);
        if (!row_full) begin
            case (dec_phase)
                pbrd_pkg::PH_CONTROL: begin
                    if ((b & pbrd_pkg::CTRL_REPEAT_BIT) != 8'h00) begin
                        units_left = pbrd_pkg::UNITS_W'(int'(pbrd_pkg::REPEAT_BASE) - int'(b));
                        dec_phase  = pbrd_pkg::PH_REPEAT_A;
                    end else begin
                        units_left  = pbrd_pkg::UNITS_W'(int'(b) + 1);
                        literal_odd = 1'b0;
                        dec_phase   = pbrd_pkg::PH_LITERAL;
                    end
                end
                pbrd_pkg::PH_REPEAT_A: begin
                    if (cfg_pair) begin
                        held_byte = b;
                        dec_phase = pbrd_pkg::PH_REPEAT_B;
                    end else begin
                        emit_run(b, b, int'(units_left));
                        units_left = '0;
                        dec_phase  = pbrd_pkg::PH_CONTROL;
                    end
                end
                pbrd_pkg::PH_REPEAT_B: begin
                    // The second byte completes the pair even if the mode has changed.
                    emit_run(held_byte, b, int'(units_left) * 2);
                    units_left = '0;
                    dec_phase  = pbrd_pkg::PH_CONTROL;
                end
                default: begin
                    if (literal_odd) begin
                        emit_run(held_byte, b, 2);
                        literal_odd = 1'b0;
                        units_left  = units_left - 1'b1;
                    end else if (cfg_pair) begin
                        held_byte   = b;
                        literal_odd = 1'b1;
                    end else begin
                        emit_run(b, b, 1);
                        units_left = units_left - 1'b1;
                    end
                    if (units_left == '0 && !literal_odd) begin
                        dec_phase = pbrd_pkg::PH_CONTROL;
                    end
                end
            endcase
        end
        if (last) begin
            // A lone held literal byte goes out as a one-byte run before the fill.
            if (dec_phase == pbrd_pkg::PH_LITERAL && literal_odd && !row_full) begin
                emit_run(held_byte, held_byte, 1);
            end
            r.first_value  = 8'h00;
            r.second_value = 8'h00;
            r.run_bytes    = pbrd_pkg::LEN_W'((produced < lim) ? lim - produced : 0);
            r.row_done     = 1'b1;
            step_runs.insert(step_runs.size(), r);
            clear_row();
        end
    endtask

    task automatic add_step(input t_step_kind kind, input int idx, input logic [31:0] value,
                            input logic last, input logic typed,
                            input pbrd_pkg::t_result want);
        t_step st;
        st.kind  = kind;
        st.idx   = idx;
        st.value = value;
        st.last  = last;
        st.typed = typed;
        st.want  = want;
        dir_steps.insert(dir_steps.size(), st);
    endtask

    // Offer one word, wait for it to be taken, then book the runs it owes.
    task automatic send_word(input logic [7:0] b, input logic last,
                             input logic typed, input pbrd_pkg::t_result want);
        if (!quiet_window() && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        decode_byte(b, last);
        if (typed) begin
            pending_runs.insert(pending_runs.size(), want);
        end else begin
            foreach (step_runs[i]) pending_runs.insert(pending_runs.size(), step_runs[i]);
        end
        words_in++;
    endtask

    // Stop offering and wait until every owed run has come out.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_runs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= pbrd_pkg::ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (idx == pbrd_pkg::REG_EXPECTED) begin
            cfg_expected = value[pbrd_pkg::LEN_W-1:0];
        end else begin
            cfg_pair = value[0];
        end
    endtask

    // Mostly well-formed rows of repeat and literal packets with random content;
    // some rows are cut at a random byte and some are plain noise.
    task automatic send_random_row();
        logic [7:0]        row_bytes[$];
        int                sel;
        int                unit;
        int                count;
        int                cut;
        pbrd_pkg::t_result none;
        none = '0;
        sel  = $urandom_range(0, 7);
        unit = cfg_pair ? 2 : 1;
        if (sel == 0) begin
            repeat ($urandom_range(1, 20)) row_bytes.insert(row_bytes.size(), 8'($urandom));
        end else begin
            repeat ($urandom_range(1, 8)) begin
                if ($urandom_range(0, 1) == 1) begin
                    row_bytes.insert(row_bytes.size(), 8'($urandom_range(128, 255)));
                    repeat (unit) row_bytes.insert(row_bytes.size(), 8'($urandom));
                end else begin
                    count = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 127)
                                                         : $urandom_range(0, 7);
                    row_bytes.insert(row_bytes.size(), 8'(count));
                    repeat ((count + 1) * unit)
                        row_bytes.insert(row_bytes.size(), 8'($urandom));
                end
            end
            if (sel == 1) begin
                cut = $urandom_range(1, row_bytes.size());
                row_bytes = row_bytes[0:cut-1];
            end
        end
        foreach (row_bytes[i]) begin
            send_word(row_bytes[i], i == row_bytes.size() - 1, 1'b0, none);
        end
    endtask

    // Receiver: random stalls, one long hold-off, and a stretch with none.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && words_in >= HOLD_AT) begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (quiet_window()) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Every word taken from the decoder is compared with the oldest owed run.
    always @(posedge i_clk) begin
        pbrd_pkg::t_result got;
        pbrd_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.first_value  = m_axis_tdata[7:0];
            got.second_value = m_axis_tdata[15:8];
            got.run_bytes    = m_axis_tdata[30:16];
            got.row_done     = m_axis_tlast;
            if (pending_runs.size() == 0) begin
                report_mismatch("word with nothing owed, run_bytes", got.run_bytes, 0);
            end else begin
                want = pending_runs.pop_front();
                if (got.first_value !== want.first_value)
                    report_mismatch("first_value", got.first_value, want.first_value);
                if (got.second_value !== want.second_value)
                    report_mismatch("second_value", got.second_value, want.second_value);
                if (got.run_bytes !== want.run_bytes)
                    report_mismatch("run_bytes", got.run_bytes, want.run_bytes);
                if (got.row_done !== want.row_done)
                    report_mismatch("row_done", got.row_done, want.row_done);
            end
            runs_checked++;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_step       st;
        int          start_words;
        logic [31:0] len_val;

        // Right after reset the row length is zero, so the row is full at once.
        add_step(STEP_WORD, 0, 8'h00, 1'b1, 1'b1, {8'h00, 8'h00, 15'd0, 1'b1});
        add_step(STEP_CFG, pbrd_pkg::REG_EXPECTED, pbrd_pkg::MAX_ROW_BYTES, 1'b0, 1'b0, '0);
        // 0x80 is the longest repeat, 129 copies.
        add_step(STEP_WORD, 0, 8'h80, 1'b0, 1'b0, '0);
        add_step(STEP_WORD, 0, 8'hFF, 1'b0, 1'b1, {8'hFF, 8'hFF, 15'd129, 1'b0});
        // The longest literal, cut off by the row end after one byte.
        add_step(STEP_WORD, 0, 8'h7F, 1'b0, 1'b0, '0);
        add_step(STEP_WORD, 0, 8'hFF, 1'b1, 1'b0, '0);
        add_step(STEP_CFG, pbrd_pkg::REG_EXPECTED, 5, 1'b0, 1'b0, '0);
        add_step(STEP_CFG, pbrd_pkg::REG_PAIR, 1, 1'b0, 1'b0, '0);
        // A pair repeat far longer than the row is clipped; the rest is ignored.
        add_step(STEP_WORD, 0, 8'h81, 1'b0, 1'b0, '0);
        add_step(STEP_WORD, 0, 8'h12, 1'b0, 1'b0, '0);
        add_step(STEP_WORD, 0, 8'h34, 1'b0, 1'b1, {8'h12, 8'h34, 15'd5, 1'b0});
        add_step(STEP_WORD, 0, 8'h55, 1'b1, 1'b1, {8'h00, 8'h00, 15'd0, 1'b1});
        // Literal pairs, the last one clipped to its first byte.
        add_step(STEP_WORD, 0, 8'h01, 1'b0, 1'b0, '0);
        add_step(STEP_WORD, 0, 8'hA1, 1'b0, 1'b0, '0);
        add_step(STEP_WORD, 0, 8'hB2, 1'b0, 1'b0, '0);
        add_step(STEP_WORD, 0, 8'hC3, 1'b0, 1'b0, '0);
        add_step(STEP_WORD, 0, 8'hD4, 1'b0, 1'b0, '0);
        add_step(STEP_WORD, 0, 8'h00, 1'b0, 1'b0, '0);
        add_step(STEP_WORD, 0, 8'hE5, 1'b0, 1'b0, '0);
        add_step(STEP_WORD, 0, 8'hF6, 1'b1, 1'b0, '0);
        // The row ends while the first byte of a literal pair is held.
        add_step(STEP_WORD, 0, 8'h00, 1'b0, 1'b0, '0);
        add_step(STEP_WORD, 0, 8'h77, 1'b1, 1'b0, '0);
        // The row ends before the repeat pair is complete: the repeat is dropped.
        add_step(STEP_WORD, 0, 8'hFE, 1'b0, 1'b0, '0);
        add_step(STEP_WORD, 0, 8'h11, 1'b1, 1'b1, {8'h00, 8'h00, 15'd5, 1'b1});
        // A length above the largest row, then a mode change inside a repeat pair.
        add_step(STEP_CFG, pbrd_pkg::REG_EXPECTED, 32767, 1'b0, 1'b0, '0);
        add_step(STEP_WORD, 0, 8'hFE, 1'b0, 1'b0, '0);
        add_step(STEP_WORD, 0, 8'h22, 1'b0, 1'b0, '0);
        add_step(STEP_CFG, pbrd_pkg::REG_PAIR, 0, 1'b0, 1'b0, '0);
        add_step(STEP_WORD, 0, 8'h33, 1'b0, 1'b0, '0);
        add_step(STEP_WORD, 0, 8'hFF, 1'b0, 1'b0, '0);
        add_step(STEP_WORD, 0, 8'h44, 1'b1, 1'b0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        clear_row();
        @(posedge i_clk);

        foreach (dir_steps[i]) begin
            st = dir_steps[i];
            if (st.kind == STEP_CFG) begin
                wait_idle();
                cfg_write(st.idx, st.value);
            end else begin
                send_word(st.value[7:0], st.last, st.typed, st.want);
            end
        end

        // Random phases: each one settles, sets a new row length and mode, sends rows.
        start_words = words_in;
        while (words_in - start_words < RANDOM_WORDS) begin
            wait_idle();
            case ($urandom_range(0, 6))
                0:       len_val = 0;
                1:       len_val = 1;
                2:       len_val = $urandom_range(2, 40);
                3:       len_val = $urandom_range(41, 700);
                4:       len_val = pbrd_pkg::MAX_ROW_BYTES;
                5:       len_val = $urandom_range(pbrd_pkg::MAX_ROW_BYTES + 1, 32767);
                default: len_val = $urandom_range(1, 200);
            endcase
            cfg_write(pbrd_pkg::REG_EXPECTED, len_val);
            cfg_write(pbrd_pkg::REG_PAIR, $urandom_range(0, 1));
            repeat ($urandom_range(1, 4)) send_random_row();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_runs.size() != 0) begin
            report_mismatch("runs left over at the end", pending_runs.size(), 0);
        end
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/pbrd_pkg.sv
rtl/pbrd_cfg.sv
rtl/pbrd_core.sv
rtl/pbrd_outq.sv
rtl/packbits_row_decoder.sv
test/tb_packbits_row_decoder.sv
